/* hw/rtl/ppcrp_pkg.sv */
`timescale 1ns / 1ps

package ppcrp_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned TYPE_W   = 8;
	localparam int unsigned SEL_W    = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_DATA_W  = 176;
	localparam int unsigned OUT_DATA_W = 32;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CTOR_ADDR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTOR_PRESENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DTOR_ADDR    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DTOR_PRESENT = 2'd3;

	// list selector codes
	localparam logic [SEL_W-1:0] SEL_CTOR = 2'd1;
	localparam logic [SEL_W-1:0] SEL_DTOR = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DYNAMIC     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_GOT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_LIST     = 3'd4;

	localparam logic [WORD_W-1:0] HALF_MASK   = 32'h0000_ffff;
	localparam logic [WORD_W-1:0] ROUND_BIT   = 32'h0000_8000;
	localparam int unsigned       HINT_BIT    = 10;

	typedef enum logic [1:0] {
		SRC_SA,
		SRC_REL,
		SRC_GOT
	} src_t;

	typedef enum logic [2:0] {
		XF_FULL,
		XF_LO,
		XF_HI,
		XF_HA,
		XF_SHR2
	} xform_t;

	// insert position and length
	typedef enum logic [2:0] {
		FLD_WORD,
		FLD_P2_L26,
		FLD_P2_L24,
		FLD_P16_L16,
		FLD_P16_L14,
		FLD_P0_L16
	} field_t;

	typedef enum logic [1:0] {
		HINT_NONE,
		HINT_SET,
		HINT_CLR
	} hint_t;

	typedef struct packed {
		logic                patch;
		logic [STATUS_W-1:0] status;
		src_t                src;
		xform_t              xform;
		field_t              field;
		hint_t               hint;
	} desc_t;

	typedef struct packed {
		desc_t             desc;
		logic [WORD_W-1:0] sa;
		logic [WORD_W-1:0] place;
		logic [WORD_W-1:0] got;
		logic [WORD_W-1:0] word;
	} entry_t;

endpackage

/* hw/rtl/ppcrp_front.sv */
`timescale 1ns / 1ps

module ppcrp_front import ppcrp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	input  logic [TYPE_W-1:0]    reloc_type,
	input  logic [SEL_W-1:0]     list_select,
	input  logic [WORD_W-1:0]    symbol_value,
	input  logic [WORD_W-1:0]    explicit_addend,
	input  logic                 addend_in_entry,
	input  logic [WORD_W-1:0]    place_address,
	input  logic [WORD_W-1:0]    target_word,
	input  logic [WORD_W-1:0]    got_entry_value,
	input  logic                 got_entry_found,
	output entry_t               entry
);

	logic [WORD_W-1:0] ctor_addr_q;
	logic              ctor_present_q;
	logic [WORD_W-1:0] dtor_addr_q;
	logic              dtor_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctor_addr_q    <= '0;
			ctor_present_q <= 1'b0;
			dtor_addr_q    <= '0;
			dtor_present_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CTOR_ADDR:    ctor_addr_q    <= cfg_wdata;
				CFG_CTOR_PRESENT: ctor_present_q <= cfg_wdata[0];
				CFG_DTOR_ADDR:    dtor_addr_q    <= cfg_wdata;
				CFG_DTOR_PRESENT: dtor_present_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic [WORD_W-1:0] sym;
	logic [WORD_W-1:0] addend;
	logic              list_missing;
	desc_t             d;

	always_comb begin
		sym          = symbol_value;
		list_missing = 1'b0;
		if (list_select == SEL_CTOR) begin
			sym          = ctor_addr_q;
			list_missing = !ctor_present_q;
		end else if (list_select == SEL_DTOR) begin
			sym          = dtor_addr_q;
			list_missing = !dtor_present_q;
		end
		addend = addend_in_entry ? explicit_addend : target_word;
	end

	// type decode
	always_comb begin
		d.patch  = 1'b1;
		d.status = ST_OK;
		d.src    = SRC_SA;
		d.xform  = XF_FULL;
		d.field  = FLD_WORD;
		d.hint   = HINT_NONE;
		unique case (reloc_type) inside
			8'd0, 8'd19, 8'd21, 8'd255: d.patch = 1'b0;
			8'd1, 8'd20, 8'd24, 8'd27: ;
			8'd26, 8'd28: d.src = SRC_REL;
			8'd2: begin
				d.xform = XF_SHR2;
				d.field = FLD_P2_L26;
			end
			8'd3, 8'd25, [8'd67:8'd94]: d.field = FLD_P16_L16;
			8'd4, 8'd29: d.field = FLD_P0_L16;
			8'd5, 8'd30: begin
				d.xform = XF_HI;
				d.field = FLD_P0_L16;
			end
			8'd6, 8'd31: begin
				d.xform = XF_HA;
				d.field = FLD_P0_L16;
			end
			8'd7, 8'd8, 8'd9: begin
				d.xform = XF_SHR2;
				d.field = FLD_P16_L14;
				if (reloc_type == 8'd8) d.hint = HINT_SET;
				if (reloc_type == 8'd9) d.hint = HINT_CLR;
			end
			8'd10, 8'd18, 8'd23: begin
				d.src   = SRC_REL;
				d.xform = XF_SHR2;
				d.field = FLD_P2_L24;
			end
			8'd11, 8'd12, 8'd13: begin
				d.src   = SRC_REL;
				d.xform = XF_SHR2;
				d.field = FLD_P16_L14;
				if (reloc_type == 8'd12) d.hint = HINT_SET;
				if (reloc_type == 8'd13) d.hint = HINT_CLR;
			end
			8'd14: begin
				d.src   = SRC_GOT;
				d.xform = XF_HI;
				d.field = FLD_P16_L16;
			end
			8'd15: begin
				d.src   = SRC_GOT;
				d.field = FLD_P0_L16;
			end
			8'd16: begin
				d.src   = SRC_GOT;
				d.xform = XF_HI;
				d.field = FLD_P0_L16;
			end
			8'd17: begin
				d.src   = SRC_GOT;
				d.xform = XF_HA;
				d.field = FLD_P0_L16;
			end
			8'd22: d.status = ST_DYNAMIC;
			8'd249, 8'd250: begin
				d.src   = SRC_REL;
				d.field = FLD_P16_L16;
			end
			8'd251: begin
				d.src   = SRC_REL;
				d.xform = XF_HI;
				d.field = FLD_P16_L16;
			end
			8'd252: begin
				d.src   = SRC_REL;
				d.xform = XF_HA;
				d.field = FLD_P16_L16;
			end
			default: d.status = ST_UNSUPPORTED;
		endcase
		if (reloc_type >= 8'd14 && reloc_type <= 8'd17 && !got_entry_found)
			d.status = ST_NO_GOT;
		// missing list table wins over anything the type says
		if (list_missing)
			d.status = ST_NO_LIST;
		if (d.status != ST_OK)
			d.patch = 1'b0;
	end

	assign entry.desc  = d;
	assign entry.sa    = sym + addend;
	assign entry.place = place_address;
	assign entry.got   = got_entry_value;
	assign entry.word  = target_word;

endmodule

/* hw/rtl/ppcrp_queue.sv */
`timescale 1ns / 1ps

module ppcrp_queue import ppcrp_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/ppcrp_back.sv */
`timescale 1ns / 1ps

module ppcrp_back import ppcrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  entry_t              head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WORD_W-1:0]   out_word,
	output logic [STATUS_W-1:0] out_status
);

	logic                valid_q;
	logic [WORD_W-1:0]   word_q;
	logic [STATUS_W-1:0] status_q;

	logic [WORD_W-1:0] rel;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] val;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] shifted;
	logic [WORD_W-1:0] patched;

	always_comb begin
		rel = head.sa - head.place;
		case (head.desc.src)
			SRC_REL: base = rel;
			SRC_GOT: base = head.got;
			default: base = head.sa;
		endcase

		case (head.desc.xform)
			XF_LO:   val = base & HALF_MASK;
			XF_HI:   val = base >> 16;
			XF_HA:   val = ((base >> 16) + {31'd0, |(base & ROUND_BIT)}) & HALF_MASK;
			XF_SHR2: val = base >> 2;
			default: val = base;
		endcase

		case (head.desc.field)
			FLD_P2_L26: begin
				mask    = 32'h0fff_fffc;
				shifted = val << 2;
			end
			FLD_P2_L24: begin
				mask    = 32'h03ff_fffc;
				shifted = val << 2;
			end
			FLD_P16_L16: begin
				mask    = 32'hffff_0000;
				shifted = val << 16;
			end
			FLD_P16_L14: begin
				mask    = 32'h3fff_0000;
				shifted = val << 16;
			end
			FLD_P0_L16: begin
				mask    = HALF_MASK;
				shifted = val;
			end
			default: begin
				mask    = '1;
				shifted = val;
			end
		endcase

		patched = (head.word & ~mask) | (shifted & mask);
		case (head.desc.hint)
			HINT_SET: patched[HINT_BIT] = 1'b1;
			HINT_CLR: patched[HINT_BIT] = 1'b0;
			default: ;
		endcase
		if (!head.desc.patch)
			patched = head.word;
	end

	assign pop = head_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q   <= patched;
			status_q <= head.desc.status;
		end
	end

	assign out_valid  = valid_q;
	assign out_word   = word_q;
	assign out_status = status_q;

endmodule

/* hw/rtl/ppc32_relocation_patcher_core.sv */
`timescale 1ns / 1ps

// PowerPC 32-bit ELF relocation patcher. Each input beat is one relocation;
// each output beat is the patched target word plus a status (0 ok,
// 1 unsupported type, 2 dynamic-only type, 3 no GOT slot, 4 no list table).
// On any error the word comes back unchanged. Throughput is one relocation
// per clock while the output is not stalled; each relocation passes through
// the decode queue and then the output register. The front decodes the type
// and forms S + A before the queue; the back forms S + A - P, shapes and
// inserts the field. The queue holds QUEUE_DEPTH decoded relocations, so
// input keeps flowing for that many beats while the output is stalled.
// Write configuration only when no relocation is in flight.

module ppc32_relocation_patcher_core import ppcrp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// reloc_type, symbol_value, explicit_addend, addend_in_entry,
	// place_address, target_word, got_entry_value, got_entry_found, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// list_select
	input  logic [SEL_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// patched_word
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [STATUS_W-1:0]   m_axis_tuser
);

	entry_t front_entry;
	entry_t head;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;
	logic   push;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	ppcrp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.reloc_type      (s_axis_tdata[7:0]),
		.list_select     (s_axis_tuser),
		.symbol_value    (s_axis_tdata[39:8]),
		.explicit_addend (s_axis_tdata[71:40]),
		.addend_in_entry (s_axis_tdata[72]),
		.place_address   (s_axis_tdata[104:73]),
		.target_word     (s_axis_tdata[136:105]),
		.got_entry_value (s_axis_tdata[168:137]),
		.got_entry_found (s_axis_tdata[169]),
		.entry           (front_entry)
	);

	ppcrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	ppcrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (m_axis_tdata),
		.out_status (m_axis_tuser)
	);

endmodule

/* test/ppcrp_tb_pkg.sv */
`timescale 1ns / 1ps

package ppcrp_tb_pkg;

	import ppcrp_pkg::*;

	// relocation type numbers, PowerPC 32-bit ABI
	localparam logic [TYPE_W-1:0] RT_NONE            = 8'd0;
	localparam logic [TYPE_W-1:0] RT_ADDR32          = 8'd1;
	localparam logic [TYPE_W-1:0] RT_ADDR24          = 8'd2;
	localparam logic [TYPE_W-1:0] RT_ADDR16          = 8'd3;
	localparam logic [TYPE_W-1:0] RT_ADDR16_LO       = 8'd4;
	localparam logic [TYPE_W-1:0] RT_ADDR16_HI       = 8'd5;
	localparam logic [TYPE_W-1:0] RT_ADDR16_HA       = 8'd6;
	localparam logic [TYPE_W-1:0] RT_ADDR14          = 8'd7;
	localparam logic [TYPE_W-1:0] RT_ADDR14_BRTAKEN  = 8'd8;
	localparam logic [TYPE_W-1:0] RT_ADDR14_BRNTAKEN = 8'd9;
	localparam logic [TYPE_W-1:0] RT_REL24           = 8'd10;
	localparam logic [TYPE_W-1:0] RT_REL14           = 8'd11;
	localparam logic [TYPE_W-1:0] RT_REL14_BRTAKEN   = 8'd12;
	localparam logic [TYPE_W-1:0] RT_REL14_BRNTAKEN  = 8'd13;
	localparam logic [TYPE_W-1:0] RT_GOT16           = 8'd14;
	localparam logic [TYPE_W-1:0] RT_GOT16_LO        = 8'd15;
	localparam logic [TYPE_W-1:0] RT_GOT16_HI        = 8'd16;
	localparam logic [TYPE_W-1:0] RT_GOT16_HA        = 8'd17;
	localparam logic [TYPE_W-1:0] RT_PLTREL24        = 8'd18;
	localparam logic [TYPE_W-1:0] RT_COPY            = 8'd19;
	localparam logic [TYPE_W-1:0] RT_GLOB_DAT        = 8'd20;
	localparam logic [TYPE_W-1:0] RT_JMP_SLOT        = 8'd21;
	localparam logic [TYPE_W-1:0] RT_RELATIVE        = 8'd22;
	localparam logic [TYPE_W-1:0] RT_LOCAL24PC       = 8'd23;
	localparam logic [TYPE_W-1:0] RT_UADDR32         = 8'd24;
	localparam logic [TYPE_W-1:0] RT_UADDR16         = 8'd25;
	localparam logic [TYPE_W-1:0] RT_REL32           = 8'd26;
	localparam logic [TYPE_W-1:0] RT_PLT32           = 8'd27;
	localparam logic [TYPE_W-1:0] RT_PLTREL32        = 8'd28;
	localparam logic [TYPE_W-1:0] RT_PLT16_LO        = 8'd29;
	localparam logic [TYPE_W-1:0] RT_PLT16_HI        = 8'd30;
	localparam logic [TYPE_W-1:0] RT_PLT16_HA        = 8'd31;
	localparam logic [TYPE_W-1:0] RT_SDAREL16        = 8'd32;
	localparam logic [TYPE_W-1:0] RT_SECTOFF_HA      = 8'd36;
	localparam logic [TYPE_W-1:0] RT_TLS_FIRST       = 8'd67;
	localparam logic [TYPE_W-1:0] RT_TLS_LAST        = 8'd94;
	localparam logic [TYPE_W-1:0] RT_REL16           = 8'd249;
	localparam logic [TYPE_W-1:0] RT_REL16_LO        = 8'd250;
	localparam logic [TYPE_W-1:0] RT_REL16_HI        = 8'd251;
	localparam logic [TYPE_W-1:0] RT_REL16_HA        = 8'd252;
	localparam logic [TYPE_W-1:0] RT_TOC16           = 8'd255;

	localparam logic [SEL_W-1:0] SEL_ORDINARY = 2'd0;
	localparam logic [SEL_W-1:0] SEL_SPARE    = 2'd3;

	typedef struct packed {
		logic [TYPE_W-1:0] reloc_type;
		logic [SEL_W-1:0]  list_select;
		logic [WORD_W-1:0] symbol_value;
		logic [WORD_W-1:0] explicit_addend;
		logic              addend_in_entry;
		logic [WORD_W-1:0] place_address;
		logic [WORD_W-1:0] target_word;
		logic [WORD_W-1:0] got_entry_value;
		logic              got_entry_found;
	} reloc_t;

	function automatic logic [IN_DATA_W-1:0] pack_reloc(input reloc_t r);
		return {6'b0, r.got_entry_found, r.got_entry_value, r.target_word, r.place_address,
			r.addend_in_entry, r.explicit_addend, r.symbol_value, r.reloc_type};
	endfunction

	function automatic reloc_t unpack_reloc(input logic [IN_DATA_W-1:0] d,
		input logic [SEL_W-1:0] u);
		reloc_t r;
		r.reloc_type      = d[7:0];
		r.symbol_value    = d[39:8];
		r.explicit_addend = d[71:40];
		r.addend_in_entry = d[72];
		r.place_address   = d[104:73];
		r.target_word     = d[136:105];
		r.got_entry_value = d[168:137];
		r.got_entry_found = d[169];
		r.list_select     = u;
		return r;
	endfunction

endpackage

/* test/ppcrp_patch_checker.sv */
`timescale 1ns / 1ps

module ppcrp_patch_checker import ppcrp_pkg::*, ppcrp_tb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [SEL_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [STATUS_W-1:0]   m_tuser,
	output int                    fault_count,
	output int                    results_owed
);

	typedef struct {
		logic [WORD_W-1:0]   word;
		logic [STATUS_W-1:0] status;
	} patch_result_t;

	patch_result_t patch_q[$];

	logic [WORD_W-1:0] ctor_addr = '0;
	logic              ctor_present = 1'b0;
	logic [WORD_W-1:0] dtor_addr = '0;
	logic              dtor_present = 1'b0;

	initial begin
		fault_count = 0;
		results_owed = 0;
	end

	function automatic logic [WORD_W-1:0] high_adj(input logic [WORD_W-1:0] v);
		return ((v >> 16) + {31'd0, (v & ROUND_BIT) != '0}) & HALF_MASK;
	endfunction

	function automatic void predict_patch(input reloc_t r, output logic [WORD_W-1:0] word,
		output logic [STATUS_W-1:0] st);
		logic [WORD_W-1:0] s, a, sa, rel, val, mask;
		int unsigned       pos, len;
		hint_t             hint;
		logic              patch;
		s     = r.symbol_value;
		a     = r.addend_in_entry ? r.explicit_addend : r.target_word;
		word  = r.target_word;
		st    = ST_OK;
		val   = '0;
		pos   = 0;
		len   = 32;
		hint  = HINT_NONE;
		patch = 1'b1;
		// list substitution is resolved before the type is looked at
		if (r.list_select == SEL_CTOR) begin
			if (ctor_present) s = ctor_addr;
			else st = ST_NO_LIST;
		end else if (r.list_select == SEL_DTOR) begin
			if (dtor_present) s = dtor_addr;
			else st = ST_NO_LIST;
		end
		sa  = s + a;
		rel = sa - r.place_address;
		if (st == ST_OK) begin
			if (r.reloc_type >= RT_GOT16 && r.reloc_type <= RT_GOT16_HA && !r.got_entry_found) begin
				st = ST_NO_GOT;
			end else if (r.reloc_type >= RT_TLS_FIRST && r.reloc_type <= RT_TLS_LAST) begin
				val = sa; pos = 16; len = 16;
			end else begin
				case (r.reloc_type)
					RT_NONE, RT_COPY, RT_JMP_SLOT, RT_TOC16: patch = 1'b0;
					RT_ADDR32, RT_GLOB_DAT, RT_UADDR32, RT_PLT32: val = sa;
					RT_REL32, RT_PLTREL32: val = rel;
					RT_ADDR24: begin val = sa >> 2; pos = 2; len = 26; end
					RT_ADDR16, RT_UADDR16: begin val = sa; pos = 16; len = 16; end
					RT_ADDR16_LO, RT_PLT16_LO: begin val = sa & HALF_MASK; len = 16; end
					RT_ADDR16_HI, RT_PLT16_HI: begin val = sa >> 16; len = 16; end
					RT_ADDR16_HA, RT_PLT16_HA: begin val = high_adj(sa); len = 16; end
					RT_ADDR14: begin val = sa >> 2; pos = 16; len = 14; end
					RT_ADDR14_BRTAKEN: begin
						val = sa >> 2; pos = 16; len = 14; hint = HINT_SET;
					end
					RT_ADDR14_BRNTAKEN: begin
						val = sa >> 2; pos = 16; len = 14; hint = HINT_CLR;
					end
					RT_REL24, RT_PLTREL24, RT_LOCAL24PC: begin
						val = rel >> 2; pos = 2; len = 24;
					end
					RT_REL14: begin val = rel >> 2; pos = 16; len = 14; end
					RT_REL14_BRTAKEN: begin
						val = rel >> 2; pos = 16; len = 14; hint = HINT_SET;
					end
					RT_REL14_BRNTAKEN: begin
						val = rel >> 2; pos = 16; len = 14; hint = HINT_CLR;
					end
					RT_GOT16: begin val = r.got_entry_value >> 16; pos = 16; len = 16; end
					RT_GOT16_LO: begin val = r.got_entry_value & HALF_MASK; len = 16; end
					RT_GOT16_HI: begin val = r.got_entry_value >> 16; len = 16; end
					RT_GOT16_HA: begin val = high_adj(r.got_entry_value); len = 16; end
					RT_RELATIVE: st = ST_DYNAMIC;
					RT_REL16: begin val = rel; pos = 16; len = 16; end
					RT_REL16_LO: begin val = rel & HALF_MASK; pos = 16; len = 16; end
					RT_REL16_HI: begin val = rel >> 16; pos = 16; len = 16; end
					RT_REL16_HA: begin val = high_adj(rel); pos = 16; len = 16; end
					default: st = ST_UNSUPPORTED;
				endcase
			end
		end
		if (st == ST_OK && patch) begin
			if (len >= 32) begin
				word = val;
			end else begin
				mask = ((32'd1 << len) - 32'd1) << pos;
				word = (word & ~mask) | ((val << pos) & mask);
			end
			if (hint == HINT_SET) word[HINT_BIT] = 1'b1;
			else if (hint == HINT_CLR) word[HINT_BIT] = 1'b0;
		end
	endfunction

	always @(posedge clk) begin : watch
		reloc_t              r;
		patch_result_t       want;
		logic [WORD_W-1:0]   w;
		logic [STATUS_W-1:0] st;
		if (arst_n) begin
			// writes only land while idle, so no beat can see a half-updated setting
			if (cfg_we) begin
				case (cfg_index)
					CFG_CTOR_ADDR:    ctor_addr = cfg_wdata;
					CFG_CTOR_PRESENT: ctor_present = cfg_wdata[0];
					CFG_DTOR_ADDR:    dtor_addr = cfg_wdata;
					CFG_DTOR_PRESENT: dtor_present = cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (patch_q.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: result beat with nothing pending: word %08h status %0d",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = patch_q.pop_front();
					if (m_tdata !== want.word || m_tuser !== want.status) begin
						fault_count++;
						if (fault_count <= 10)
							$display("%0t: mismatch: word exp %08h got %08h, status exp %0d got %0d",
								$realtime, want.word, m_tdata, want.status, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				r = unpack_reloc(s_tdata, s_tuser);
				predict_patch(r, w, st);
				patch_q.push_back('{word: w, status: st});
			end
		end
		results_owed <= patch_q.size();
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import ppcrp_pkg::*;
	import ppcrp_tb_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]     cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [SEL_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	int                    fault_count;
	int                    results_owed;
	bit                    sender_steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ppc32_relocation_patcher_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	ppcrp_patch_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fault_count  (fault_count),
		.results_owed (results_owed)
	);

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			// land right on the carry boundary of the adjusted high half
			2: return ($urandom & ~HALF_MASK) | ROUND_BIT;
			3: return ($urandom & ~HALF_MASK) | (ROUND_BIT - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic reloc_t mk_reloc(input logic [TYPE_W-1:0] t, input logic [SEL_W-1:0] sel,
		input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] a, input logic use_a,
		input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] g,
		input logic g_ok);
		reloc_t r;
		r.reloc_type      = t;
		r.list_select     = sel;
		r.symbol_value    = s;
		r.explicit_addend = a;
		r.addend_in_entry = use_a;
		r.place_address   = p;
		r.target_word     = w;
		r.got_entry_value = g;
		r.got_entry_found = g_ok;
		return r;
	endfunction

	// caller sits at a clock edge; returns at the edge after the last write
	task automatic write_lists(input logic [WORD_W-1:0] ctor_a, input logic ctor_p,
		input logic [WORD_W-1:0] dtor_a, input logic dtor_p);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CTOR_ADDR;
		cfg_wdata <= ctor_a;
		@(posedge clk);
		cfg_index <= CFG_CTOR_PRESENT;
		cfg_wdata <= WORD_W'(ctor_p);
		@(posedge clk);
		cfg_index <= CFG_DTOR_ADDR;
		cfg_wdata <= dtor_a;
		@(posedge clk);
		cfg_index <= CFG_DTOR_PRESENT;
		cfg_wdata <= WORD_W'(dtor_p);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_reloc(input reloc_t r);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_reloc(r);
		s_tuser <= r.list_select;
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// result side: random stalls, calm stretches, and one long hold to back up the queue
	initial begin : result_sink
		int stall;
		int taken;
		bit steady;
		taken = 0;
		steady = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken == 60) stall = 400;
			else if (steady) stall = 0;
			else stall = $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if ($urandom_range(0, 39) == 0) steady = !steady;
		end
	end

	initial begin : stimulus
		reloc_t dir_q[$];
		reloc_t r;
		int     phase;
		int     n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// constructor list present at the top address, destructor list absent
		write_lists('1, 1'b1, '0, 1'b0);
		dir_q.push_back(mk_reloc(RT_NONE, SEL_ORDINARY, '1, '1, 1'b1, '1, 32'hdead_beef, '1, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR32, SEL_ORDINARY, '1, '1, 1'b1, '0, '0, '0, 1'b0));
		dir_q.push_back(mk_reloc(RT_ADDR32, SEL_ORDINARY, '0, '0, 1'b1, '0, '0, '0, 1'b0));
		dir_q.push_back(mk_reloc(RT_ADDR24, SEL_ORDINARY, 32'h0123_4567, 32'h10, 1'b1, '0, '1,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR16, SEL_ORDINARY, 32'h1234_8000, 32'h1, 1'b1, '0, '1,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR16_LO, SEL_ORDINARY, 32'hfedc_ba98, 32'h1, 1'b1, '0,
			32'h5555_aaaa, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR16_HI, SEL_ORDINARY, 32'hfedc_ba98, 32'h1, 1'b1, '0,
			32'h5555_aaaa, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR16_HA, SEL_ORDINARY, 32'h1234_8000, '0, 1'b1, '0, '0,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR14_BRTAKEN, SEL_ORDINARY, '1, 32'h4, 1'b1, '0, '0,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR14_BRNTAKEN, SEL_ORDINARY, 32'h0000_fffc, '0, 1'b1, '0,
			'1, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_REL24, SEL_ORDINARY, '0, '0, 1'b1, 32'h4, 32'h4800_0001,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_REL14_BRTAKEN, SEL_ORDINARY, 32'h100, '0, 1'b1, 32'h200,
			32'h4182_0000, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_REL32, SEL_ORDINARY, 32'h1000, 32'hffff_ffff, 1'b0, 32'h10,
			32'h0000_0020, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_GOT16_HA, SEL_ORDINARY, '0, '0, 1'b1, '0, '1, 32'hffff_8000,
			1'b1));
		dir_q.push_back(mk_reloc(RT_GOT16, SEL_ORDINARY, '0, '0, 1'b1, '0, 32'h1234_5678, '1,
			1'b0));
		dir_q.push_back(mk_reloc(RT_RELATIVE, SEL_ORDINARY, '1, '1, 1'b1, '1, 32'h0bad_f00d, '1,
			1'b1));
		dir_q.push_back(mk_reloc(RT_SDAREL16, SEL_ORDINARY, '1, '1, 1'b1, '1, 32'h1111_2222,
			'1, 1'b1));
		dir_q.push_back(mk_reloc(RT_SECTOFF_HA, SEL_ORDINARY, '1, '1, 1'b1, '1, 32'h3333_4444,
			'1, 1'b1));
		dir_q.push_back(mk_reloc(TYPE_W'(RT_TLS_LAST + 1), SEL_ORDINARY, '1, '1, 1'b1, '1,
			32'h7777_8888, '1, 1'b1));
		dir_q.push_back(mk_reloc(RT_TLS_FIRST, SEL_ORDINARY, 32'h0001_ffff, 32'h1, 1'b1, '0, '0,
			'0, 1'b1));
		dir_q.push_back(mk_reloc(RT_REL16_HA, SEL_ORDINARY, 32'h0001_8000, '0, 1'b1,
			32'h0000_0001, '0, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_TOC16, SEL_ORDINARY, '1, '1, 1'b1, '1, 32'hcafe_babe, '1,
			1'b1));
		dir_q.push_back(mk_reloc(RT_ADDR32, SEL_CTOR, '0, 32'h1, 1'b1, '0, '0, '0, 1'b1));
		dir_q.push_back(mk_reloc(RT_GOT16, SEL_DTOR, '0, '0, 1'b1, '0, 32'h9999_0000, '0, 1'b0));
		dir_q.push_back(mk_reloc(RT_ADDR32, SEL_SPARE, 32'h8000_0000, 32'h8000_0000, 1'b1, '0,
			'1, '0, 1'b1));
		foreach (dir_q[i]) send_reloc(dir_q[i]);
		wait_drained();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_lists($urandom, 1'b1, $urandom, 1'b1);
				1: write_lists('0, 1'b0, '1, 1'b1);
				2: write_lists('1, 1'b1, '0, 1'b0);
				3: write_lists($urandom, 1'b0, $urandom, 1'b0);
				default: write_lists(rand_word(), 1'($urandom), rand_word(), 1'($urandom));
			endcase
			for (n = 0; n < 150; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5:
						r.reloc_type = TYPE_W'($urandom_range(RT_NONE, RT_PLT16_HA));
					6: r.reloc_type = TYPE_W'($urandom_range(RT_TLS_FIRST, RT_TLS_LAST));
					7: r.reloc_type = ($urandom_range(0, 4) == 0) ? RT_TOC16 :
						TYPE_W'($urandom_range(RT_REL16, RT_REL16_HA));
					8: r.reloc_type = TYPE_W'($urandom_range(RT_SDAREL16, RT_SECTOFF_HA));
					default: r.reloc_type = TYPE_W'($urandom);
				endcase
				case ($urandom_range(0, 5))
					3: r.list_select = SEL_CTOR;
					4: r.list_select = SEL_DTOR;
					5: r.list_select = SEL_SPARE;
					default: r.list_select = SEL_ORDINARY;
				endcase
				r.symbol_value    = rand_word();
				r.explicit_addend = rand_word();
				r.addend_in_entry = 1'($urandom);
				r.place_address   = rand_word();
				r.target_word     = rand_word();
				r.got_entry_value = rand_word();
				r.got_entry_found = ($urandom_range(0, 7) != 0);
				send_reloc(r);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
